FILE: rtl/fcdd_pkg.sv
// Package with shared constants for the frame content drop detector.
package fcdd_pkg;

	localparam int unsigned FCDD_MAX_FRAME_PIXELS = 131072;

	localparam int unsigned CNT_OUT_W = 18;
	localparam int unsigned PCT_W     = 7;
	localparam int unsigned EVT_W     = 8;
	localparam int unsigned FRAME_W   = 32;
	localparam int unsigned RGB_W     = 24;
	localparam int unsigned APB_DW    = 32;
	localparam int unsigned APB_AW    = 4;

	localparam logic [PCT_W-1:0]     DROP_PCT_RST   = 7'd85;
	localparam logic [CNT_OUT_W-1:0] MIN_PREV_RST   = 18'd3000;
	localparam logic [CNT_OUT_W-1:0] MIN_CUR_RST    = 18'd100;
	localparam logic [EVT_W-1:0]     MAX_EVENTS_RST = 8'd8;

	localparam logic [PCT_W-1:0] PERCENT_SCALE = 7'd100;

	localparam logic [1:0] REG_DROP_PCT   = 2'd0;
	localparam logic [1:0] REG_MIN_PREV   = 2'd1;
	localparam logic [1:0] REG_MIN_CUR    = 2'd2;
	localparam logic [1:0] REG_MAX_EVENTS = 2'd3;

endpackage

FILE: rtl/frame_content_drop_detector_unit.sv
// Top level of the frame content drop detector: pixel counter, frame statistics and APB registers.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  pixel   | in        | in_valid, in_stall | pixel_rgb, end_of_frame
//  result  | out       | out_valid, out_stall | frame_nonblack, drop_event, event_index,
//          |           |                    | lowest_count, highest_count, biggest_drop,
//          |           |                    | frame_number
//  config  | in        | APB psel/penable   | paddr, pwdata, prdata
//
// A pixel transfer is taken every cycle unless a frame end is held in the input register;
// each pixel passes through the input register, and a frame's result is loaded from there
// into the result register, which raises result valid.
// Reset clears the counters and statistics and loads the register defaults.
// Pixels that do not end a frame keep flowing while a result is stalled; a frame end
// waits in the input register until the result register is free.
module frame_content_drop_detector_unit
	import fcdd_pkg::*;
#(
	parameter int unsigned MAX_FRAME_PIXELS = FCDD_MAX_FRAME_PIXELS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [RGB_W-1:0]      pixel_rgb,
	input  logic                  end_of_frame,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [CNT_OUT_W-1:0]  frame_nonblack,
	output logic                  drop_event,
	output logic [EVT_W-1:0]      event_index,
	output logic [CNT_OUT_W-1:0]  lowest_count,
	output logic [CNT_OUT_W-1:0]  highest_count,
	output logic [CNT_OUT_W-1:0]  biggest_drop,
	output logic [FRAME_W-1:0]    frame_number,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_AW-1:0]     paddr,
	input  logic [APB_DW-1:0]     pwdata,
	output logic [APB_DW-1:0]     prdata,
	output logic                  pready
);

	localparam int unsigned CntW = $clog2(MAX_FRAME_PIXELS + 1);
	localparam int unsigned CmpW = (CntW > CNT_OUT_W) ? CntW : CNT_OUT_W;
	localparam int unsigned PrdW = CntW + PCT_W;
	localparam logic [CntW-1:0] CntMax = CntW'(MAX_FRAME_PIXELS);

	logic [PCT_W-1:0]     drop_pct_q;
	logic [CNT_OUT_W-1:0] min_prev_q;
	logic [CNT_OUT_W-1:0] min_cur_q;
	logic [EVT_W-1:0]     evt_cap_q;

	logic                 valid_s1;
	logic                 nonblack_s1;
	logic                 eof_s1;

	logic [CntW-1:0]      run_cnt_q;
	logic [CntW-1:0]      prior_q;
	logic                 have_prior_q;
	logic [CntW-1:0]      low_q;
	logic [CntW-1:0]      high_q;
	logic [CntW-1:0]      drop_q;
	logic [EVT_W-1:0]     evt_q;
	logic [FRAME_W-1:0]   frames_q;
	logic                 out_valid_q;

	logic                 cfg_wr;
	logic                 out_free;
	logic                 adv;
	logic                 in_take;
	logic                 cnt_inc;
	logic [CntW-1:0]      cur;
	logic [CntW-1:0]      diff;
	logic [CntW-1:0]      low_nxt;
	logic [CntW-1:0]      high_nxt;
	logic [CntW-1:0]      drop_nxt;
	logic [PrdW-1:0]      prod_cur;
	logic [PrdW-1:0]      prod_prev;
	logic                 evt_hit;
	logic [CmpW-1:0]      cur_x;
	logic [CmpW-1:0]      low_x;
	logic [CmpW-1:0]      high_x;
	logic [CmpW-1:0]      drop_x;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_pct_q   <= DROP_PCT_RST;
			min_prev_q   <= MIN_PREV_RST;
			min_cur_q    <= MIN_CUR_RST;
			evt_cap_q    <= MAX_EVENTS_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_DROP_PCT:   drop_pct_q   <= pwdata[PCT_W-1:0];
				REG_MIN_PREV:   min_prev_q   <= pwdata[CNT_OUT_W-1:0];
				REG_MIN_CUR:    min_cur_q    <= pwdata[CNT_OUT_W-1:0];
				REG_MAX_EVENTS: evt_cap_q    <= pwdata[EVT_W-1:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_DROP_PCT:   prdata = APB_DW'(drop_pct_q);
			REG_MIN_PREV:   prdata = APB_DW'(min_prev_q);
			REG_MIN_CUR:    prdata = APB_DW'(min_cur_q);
			REG_MAX_EVENTS: prdata = APB_DW'(evt_cap_q);
			default:        prdata = '0;
		endcase
	end

	assign out_free = !out_valid_q || !out_stall;
	assign adv      = valid_s1 && (!eof_s1 || out_free);
	assign in_stall = valid_s1 && !adv;
	assign in_take  = in_valid && !in_stall;

	assign cnt_inc = nonblack_s1 && (run_cnt_q < CntMax);
	assign cur     = run_cnt_q + CntW'(cnt_inc);
	assign diff    = prior_q - cur;

	assign low_nxt  = (cur < low_q) ? cur : low_q;
	assign high_nxt = (cur > high_q) ? cur : high_q;
	assign drop_nxt = (have_prior_q && (prior_q > cur) && (diff > drop_q)) ? diff : drop_q;

	assign prod_cur  = PrdW'(cur) * PrdW'(PERCENT_SCALE);
	assign prod_prev = PrdW'(prior_q) * PrdW'(drop_pct_q);

	assign evt_hit = have_prior_q && (evt_q < evt_cap_q)
		&& (CmpW'(prior_q) >= CmpW'(min_prev_q))
		&& (CmpW'(cur) >= CmpW'(min_cur_q))
		&& (prod_cur < prod_prev);

	assign cur_x  = CmpW'(cur);
	assign low_x  = CmpW'(low_nxt);
	assign high_x = CmpW'(high_nxt);
	assign drop_x = CmpW'(drop_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			nonblack_s1 <= (pixel_rgb != '0);
			eof_s1      <= end_of_frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_cnt_q    <= '0;
			prior_q      <= '0;
			have_prior_q <= 1'b0;
			low_q        <= CntMax;
			high_q       <= '0;
			drop_q       <= '0;
			evt_q        <= '0;
			frames_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			out_valid_q <= (adv && eof_s1) || (out_valid_q && out_stall);
			if (adv) begin
				if (eof_s1) begin
					run_cnt_q    <= '0;
					prior_q      <= cur;
					have_prior_q <= 1'b1;
					low_q        <= low_nxt;
					high_q       <= high_nxt;
					drop_q       <= drop_nxt;
					frames_q     <= frames_q + FRAME_W'(1);
					if (evt_hit) begin
						evt_q <= evt_q + EVT_W'(1);
					end
				end else begin
					run_cnt_q <= cur;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && eof_s1) begin
			frame_nonblack <= cur_x[CNT_OUT_W-1:0];
			drop_event     <= evt_hit;
			event_index    <= evt_hit ? evt_q : '0;
			lowest_count   <= low_x[CNT_OUT_W-1:0];
			highest_count  <= high_x[CNT_OUT_W-1:0];
			biggest_drop   <= drop_x[CNT_OUT_W-1:0];
			frame_number   <= frames_q + FRAME_W'(1);
		end
	end

	assign out_valid = out_valid_q;

	a_idx_only_on_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !drop_event |-> event_index == '0)
		else $error("event_index is nonzero on a result without an event");

	a_low_not_above_high: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> lowest_count <= highest_count)
		else $error("lowest_count exceeds highest_count");

	a_no_stall_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> !in_stall)
		else $error("input stalled while the result register is empty");

	a_frame_steps: assert property (@(posedge clk) disable iff (!arst_n)
		adv && eof_s1 |=> frame_number == frames_q)
		else $error("frame_number does not match the completed frame count");

endmodule

FILE: bench/frame_content_drop_detector_unit_tb.sv
// Self-checking testbench for the frame content drop detector, with scoreboard and stimulus.
`timescale 1ns / 100ps

typedef struct packed {
	logic [fcdd_pkg::CNT_OUT_W-1:0] frame_nonblack;
	logic                           drop_event;
	logic [fcdd_pkg::EVT_W-1:0]     event_index;
	logic [fcdd_pkg::CNT_OUT_W-1:0] lowest_count;
	logic [fcdd_pkg::CNT_OUT_W-1:0] highest_count;
	logic [fcdd_pkg::CNT_OUT_W-1:0] biggest_drop;
	logic [fcdd_pkg::FRAME_W-1:0]   frame_number;
} frame_stats_t;

class frame_stats_scoreboard;
	logic [fcdd_pkg::PCT_W-1:0]     drop_pct;
	logic [fcdd_pkg::CNT_OUT_W-1:0] min_prev;
	logic [fcdd_pkg::CNT_OUT_W-1:0] min_cur;
	logic [fcdd_pkg::EVT_W-1:0]     evt_cap;

	logic [fcdd_pkg::CNT_OUT_W-1:0] pixel_count;
	logic [fcdd_pkg::CNT_OUT_W-1:0] last_count;
	logic                           seen_frame;
	logic [fcdd_pkg::CNT_OUT_W-1:0] lowest;
	logic [fcdd_pkg::CNT_OUT_W-1:0] highest;
	logic [fcdd_pkg::CNT_OUT_W-1:0] worst_drop;
	logic [fcdd_pkg::EVT_W-1:0]     event_count;
	logic [fcdd_pkg::FRAME_W-1:0]   frames_seen;

	frame_stats_t expected_frames[$];
	int unsigned  errors;

	function new();
		drop_pct    = fcdd_pkg::DROP_PCT_RST;
		min_prev    = fcdd_pkg::MIN_PREV_RST;
		min_cur     = fcdd_pkg::MIN_CUR_RST;
		evt_cap     = fcdd_pkg::MAX_EVENTS_RST;
		pixel_count = '0;
		last_count  = '0;
		seen_frame  = 1'b0;
		lowest      = fcdd_pkg::CNT_OUT_W'(fcdd_pkg::FCDD_MAX_FRAME_PIXELS);
		highest     = '0;
		worst_drop  = '0;
		event_count = '0;
		frames_seen = '0;
		errors      = 0;
	endfunction

	function void write_register(logic [1:0] idx, logic [31:0] value);
		case (idx)
			fcdd_pkg::REG_DROP_PCT: begin
				drop_pct = value[fcdd_pkg::PCT_W-1:0];
			end
			fcdd_pkg::REG_MIN_PREV: begin
				min_prev = value[fcdd_pkg::CNT_OUT_W-1:0];
			end
			fcdd_pkg::REG_MIN_CUR: begin
				min_cur = value[fcdd_pkg::CNT_OUT_W-1:0];
			end
			default: begin
				evt_cap = value[fcdd_pkg::EVT_W-1:0];
			end
		endcase
	endfunction

	function void note_pixel(logic [fcdd_pkg::RGB_W-1:0] rgb, logic eof);
		frame_stats_t stats;
		logic [31:0]  cur_scaled;
		logic [31:0]  prev_scaled;
		if (rgb != '0 && pixel_count < fcdd_pkg::FCDD_MAX_FRAME_PIXELS)
			pixel_count = pixel_count + 1'b1;
		if (!eof)
			return;
		if (pixel_count < lowest)
			lowest = pixel_count;
		if (pixel_count > highest)
			highest = pixel_count;
		if (seen_frame && last_count > pixel_count && last_count - pixel_count > worst_drop)
			worst_drop = last_count - pixel_count;
		cur_scaled  = 32'(pixel_count) * 32'(fcdd_pkg::PERCENT_SCALE);
		prev_scaled = 32'(last_count) * 32'(drop_pct);
		stats.drop_event  = 1'b0;
		stats.event_index = '0;
		if (seen_frame && event_count < evt_cap && last_count >= min_prev &&
				pixel_count >= min_cur && cur_scaled < prev_scaled) begin
			stats.drop_event  = 1'b1;
			stats.event_index = event_count;
			event_count       = event_count + 1'b1;
		end
		last_count  = pixel_count;
		seen_frame  = 1'b1;
		frames_seen = frames_seen + 1'b1;
		stats.frame_nonblack = pixel_count;
		stats.lowest_count   = lowest;
		stats.highest_count  = highest;
		stats.biggest_drop   = worst_drop;
		stats.frame_number   = frames_seen;
		expected_frames.push_back(stats);
		pixel_count = '0;
	endfunction

	function void compare_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	function void check_frame(frame_stats_t got);
		frame_stats_t want;
		if (expected_frames.size() == 0) begin
			$error("frame result transfer with no frame end pending");
			errors++;
			return;
		end
		want = expected_frames.pop_front();
		compare_field("frame_nonblack", want.frame_nonblack, got.frame_nonblack);
		compare_field("drop_event", want.drop_event, got.drop_event);
		compare_field("event_index", want.event_index, got.event_index);
		compare_field("lowest_count", want.lowest_count, got.lowest_count);
		compare_field("highest_count", want.highest_count, got.highest_count);
		compare_field("biggest_drop", want.biggest_drop, got.biggest_drop);
		compare_field("frame_number", want.frame_number, got.frame_number);
	endfunction
endclass

module frame_content_drop_detector_unit_tb;
	import fcdd_pkg::*;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [RGB_W-1:0]     pixel_rgb;
	logic                 end_of_frame;
	logic                 out_valid;
	logic                 out_stall;
	logic [CNT_OUT_W-1:0] frame_nonblack;
	logic                 drop_event;
	logic [EVT_W-1:0]     event_index;
	logic [CNT_OUT_W-1:0] lowest_count;
	logic [CNT_OUT_W-1:0] highest_count;
	logic [CNT_OUT_W-1:0] biggest_drop;
	logic [FRAME_W-1:0]   frame_number;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [APB_AW-1:0]    paddr;
	logic [APB_DW-1:0]    pwdata;
	logic [APB_DW-1:0]    prdata;
	logic                 pready;

	frame_stats_scoreboard sb;
	int unsigned burst_left;
	int unsigned burst_max;
	int unsigned gap_max;
	int unsigned random_items;

	frame_content_drop_detector_unit uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.pixel_rgb      (pixel_rgb),
		.end_of_frame   (end_of_frame),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.frame_nonblack (frame_nonblack),
		.drop_event     (drop_event),
		.event_index    (event_index),
		.lowest_count   (lowest_count),
		.highest_count  (highest_count),
		.biggest_drop   (biggest_drop),
		.frame_number   (frame_number),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	always #5 clk = ~clk;

	task automatic send_pixel(input logic [RGB_W-1:0] rgb, input logic eof);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(burst_max, 1);
			gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid     <= 1'b1;
		pixel_rgb    <= rgb;
		end_of_frame <= eof;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		sb.note_pixel(rgb, eof);
		@(negedge clk);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		forever begin
			@(posedge clk);
			if (pready)
				break;
		end
		sb.write_register(idx, value);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.expected_frames.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic configure(input logic [31:0] pct, input logic [31:0] prev_floor,
			input logic [31:0] cur_floor, input logic [31:0] event_limit);
		wait_drained();
		write_register(REG_DROP_PCT, pct);
		write_register(REG_MIN_PREV, prev_floor);
		write_register(REG_MIN_CUR, cur_floor);
		write_register(REG_MAX_EVENTS, event_limit);
	endtask

	function automatic logic [RGB_W-1:0] random_pixel(int unsigned black_pct);
		logic [RGB_W-1:0] rgb;
		if ($urandom_range(99, 0) < black_pct)
			return '0;
		if ($urandom_range(3, 0) == 0)
			rgb = RGB_W'(1) << $urandom_range(RGB_W - 1, 0);
		else
			rgb = RGB_W'($urandom());
		if (rgb == '0)
			rgb = RGB_W'(1);
		return rgb;
	endfunction

	task automatic random_phase();
		logic [31:0] cfg [4];
		int unsigned frames;
		int unsigned len;
		int unsigned black_pct;
		case ($urandom_range(5, 0))
			0: cfg[0] = 0;
			1: cfg[0] = 100;
			2: cfg[0] = 127;
			default: cfg[0] = $urandom_range(100, 30);
		endcase
		case ($urandom_range(4, 0))
			0: cfg[1] = 0;
			1: cfg[1] = FCDD_MAX_FRAME_PIXELS;
			default: cfg[1] = $urandom_range(30, 0);
		endcase
		case ($urandom_range(4, 0))
			0: cfg[2] = 0;
			1: cfg[2] = FCDD_MAX_FRAME_PIXELS;
			default: cfg[2] = $urandom_range(15, 0);
		endcase
		case ($urandom_range(3, 0))
			0: cfg[3] = 0;
			1: cfg[3] = 255;
			default: cfg[3] = $urandom_range(12, 1);
		endcase
		if ($urandom_range(5, 0) == 0)
			cfg[$urandom_range(3, 0)] = $urandom();
		configure(cfg[0], cfg[1], cfg[2], cfg[3]);
		case ($urandom_range(2, 0))
			0: begin
				gap_max   = 0;
				burst_max = 1;
			end
			1: begin
				gap_max   = 2;
				burst_max = 4;
			end
			default: begin
				gap_max   = 8;
				burst_max = 20;
			end
		endcase
		frames = $urandom_range(20, 4);
		repeat (frames) begin
			len = ($urandom_range(5, 0) == 0) ? 1 : $urandom_range(40, 1);
			case ($urandom_range(3, 0))
				0: black_pct = 0;
				1: black_pct = 30;
				2: black_pct = 70;
				default: black_pct = 100;
			endcase
			for (int unsigned i = 1; i <= len; i++)
				send_pixel(random_pixel(black_pct), i == len);
			random_items += len;
		end
	endtask

	initial begin
		int stall_pct;
		int unsigned stretch;
		out_stall = 1'b0;
		stall_pct = 0;
		stretch   = 0;
		forever begin
			@(negedge clk);
			if (stretch == 0) begin
				stretch = $urandom_range(300, 20);
				case ($urandom_range(3, 0))
					0: stall_pct = 0;
					1: stall_pct = 25;
					2: stall_pct = 50;
					default: stall_pct = 90;
				endcase
			end
			stretch--;
			out_stall <= ($urandom_range(99, 0) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_frame('{frame_nonblack, drop_event, event_index, lowest_count,
				highest_count, biggest_drop, frame_number});
	end

	initial begin
		#10_000_000;
		$display("frame_content_drop_detector_unit_tb NOT OK");
		$finish;
	end

	initial begin
		sb           = new();
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		pixel_rgb    = '0;
		end_of_frame = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		burst_left   = 0;
		burst_max    = 4;
		gap_max      = 3;
		random_items = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_pixel(24'hFFFFFF, 1'b1);
		send_pixel(24'h000000, 1'b1);
		send_pixel(24'h000001, 1'b0);
		send_pixel(24'h800000, 1'b0);
		send_pixel(24'h000000, 1'b0);
		send_pixel(24'h123456, 1'b1);

		configure(100, 0, 0, 2);
		repeat (4) send_pixel(24'hA5A5A5, 1'b0);
		send_pixel(24'h5A5A5A, 1'b1);
		send_pixel(24'h0000FF, 1'b1);
		send_pixel(24'h000000, 1'b1);
		send_pixel(24'h000000, 1'b1);
		send_pixel(24'h00FF00, 1'b0);
		send_pixel(24'hFF0000, 1'b1);

		configure(0, FCDD_MAX_FRAME_PIXELS, FCDD_MAX_FRAME_PIXELS, 255);
		gap_max   = 0;
		burst_max = 1;
		for (int unsigned i = 1; i <= 40; i++)
			send_pixel(random_pixel(0), i == 40);
		send_pixel(24'h010101, 1'b0);
		send_pixel(24'h000000, 1'b1);

		configure(127, 0, 0, 255);
		repeat (3) send_pixel(24'h7F7F7F, 1'b0);
		send_pixel(24'h000000, 1'b1);
		send_pixel(24'h000002, 1'b1);

		while (random_items < 1700)
			random_phase();

		wait_drained();
		repeat (10) @(negedge clk);
		if (sb.errors == 0 && sb.expected_frames.size() == 0)
			$display("frame_content_drop_detector_unit_tb OK");
		else
			$display("frame_content_drop_detector_unit_tb NOT OK");
		$finish;
	end

endmodule
